[rtl/decimal_sci_normalize_compare_defines.svh]
// Assertion macros used by the port-level checker of the normalizer block.
`ifndef DECIMAL_SCI_NORMALIZE_COMPARE_DEFINES_SVH
`define DECIMAL_SCI_NORMALIZE_COMPARE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DSCN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DSCN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dscn_pkg.sv]
// Types and constants shared by the decimal normalizer and compare block.
package dscn_pkg;

    localparam int CHAR_W      = 8;
    localparam int DIG_W       = 4;
    localparam int CNT_W       = 5;
    localparam int MAX_DIGITS  = 16;
    localparam int SIG_W       = MAX_DIGITS * DIG_W;
    localparam int EXP_W       = 9;
    localparam int EXP_LIMIT   = 128;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [CNT_W-1:0] SIG_DIGITS_RESET = 5'd16;

    // What one character means to the back end.
    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_POINT,
        CLS_DIGIT
    } t_char_class;

    // One classified character as it travels through the queue.
    typedef struct packed {
        t_char_class        char_class;
        logic [DIG_W-1:0]   digit;
        logic               mode;
        logic               last;
    } t_front_beat;

    // Queue head handed from the front end to the back end.
    typedef struct packed {
        logic        valid;
        t_front_beat beat;
    } t_queue_head;

endpackage

[rtl/dscn_in_if.sv]
// Character channel: one ASCII character of a number per beat.
interface dscn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       mode;
    logic       last_char;

    modport source (output valid, output char_code, output mode, output last_char,
                    input ready);
    modport sink   (input valid, input char_code, input mode, input last_char,
                    output ready);
endinterface

[rtl/dscn_out_if.sv]
// Result channel: one normalized number per beat.
interface dscn_out_if;
    logic              valid;
    logic              ready;
    logic              which_number;
    logic [63:0]       significand_bcd;
    logic signed [8:0] exponent;
    logic              is_zero;
    logic              numbers_equal;

    modport source (output valid, output which_number, output significand_bcd,
                    output exponent, output is_zero, output numbers_equal,
                    input ready);
    modport sink   (input valid, input which_number, input significand_bcd,
                    input exponent, input is_zero, input numbers_equal,
                    output ready);
endinterface

[rtl/dscn_front.sv]
// Front end: accepts characters, classifies them and queues them for the back end.
module dscn_front
    import dscn_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    dscn_in_if.sink        i_in,
    output t_queue_head    o_head,
    input  logic           i_pop
);

    t_front_beat                    r_queue [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]             r_wr_ptr;
    logic [Q_PTR_W-1:0]             r_rd_ptr;
    logic [Q_PTR_W:0]               r_count;
    logic [Q_PTR_W-1:0]             n_wr_ptr;
    logic [Q_PTR_W-1:0]             n_rd_ptr;
    logic [Q_PTR_W:0]               n_count;
    t_front_beat                    s_beat;
    logic                           s_push;
    logic                           s_pop;

    // Classify the incoming character.
    always_comb begin
        s_beat.mode  = i_in.mode;
        s_beat.last  = i_in.last_char;
        s_beat.digit = '0;
        unique case (i_in.char_code) inside
            CHAR_POINT: begin
                s_beat.char_class = CLS_POINT;
            end
            [CHAR_ZERO:CHAR_NINE]: begin
                s_beat.char_class = CLS_DIGIT;
                s_beat.digit      = DIG_W'(i_in.char_code - CHAR_ZERO);
            end
            default: begin
                s_beat.char_class = CLS_OTHER;
            end
        endcase
    end

    // Queue handshake: a beat is taken whenever a slot is free.
    assign i_in.ready    = (r_count != (Q_PTR_W + 1)'(QUEUE_DEPTH));
    assign s_push        = i_in.valid && i_in.ready;
    assign s_pop         = i_pop && (r_count != '0);
    assign o_head.valid  = (r_count != '0);
    assign o_head.beat   = r_queue[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = s_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = s_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (s_push && !s_pop) begin
            n_count = r_count + 1'b1;
        end else if (!s_push && s_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_queue[r_wr_ptr] <= s_beat;
        end
    end

endmodule

[rtl/dscn_back.sv]
// Back end: tracks point and first nonzero digit, collects digits and forms each result.
module dscn_back
    import dscn_pkg::*;
#(
    parameter int MAX_CHARS = 128,
    parameter int POS_W     = 8
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_cnt,
    input  t_queue_head       i_head,
    output logic              o_pop,
    dscn_out_if.source        o_res
);

    localparam int DIFF_W = (POS_W + 2 > EXP_W + 1) ? POS_W + 2 : EXP_W + 1;

    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_pt_seen, n_pt_seen;
    logic [POS_W-1:0]        r_pt_pos, n_pt_pos;
    logic                    r_sig_seen, n_sig_seen;
    logic [POS_W-1:0]        r_fs_pos, n_fs_pos;
    logic [SIG_W-1:0]        r_buf, n_buf;
    logic [CNT_W-1:0]        r_ncol, n_ncol;
    logic [SIG_W-1:0]        r_sv_digs;
    logic signed [EXP_W-1:0] r_sv_exp;
    logic                    r_sv_zero;

    logic                    r_out_valid;
    logic                    r_out_which;
    logic [SIG_W-1:0]        r_out_digs;
    logic signed [EXP_W-1:0] r_out_exp;
    logic                    r_out_zero;
    logic                    r_out_eq;

    logic                    s_take;
    logic                    s_finish;
    logic [SIG_W-1:0]        s_mask;
    logic [SIG_W-1:0]        s_digs;
    logic                    s_zero;
    logic [POS_W-1:0]        s_dp;
    logic signed [DIFF_W-1:0] s_diff;
    logic signed [DIFF_W-1:0] s_diff_adj;
    logic signed [EXP_W-1:0] s_exp;
    logic                    s_eq;

    // A beat that ends a number waits until the output register is free.
    assign s_take   = i_head.valid &&
                      (!i_head.beat.last || !r_out_valid || o_res.ready);
    assign s_finish = s_take && i_head.beat.last;
    assign o_pop    = s_take;

    // Per-character update of the number being read.
    always_comb begin
        n_pos      = r_pos;
        n_pt_seen  = r_pt_seen;
        n_pt_pos   = r_pt_pos;
        n_sig_seen = r_sig_seen;
        n_fs_pos   = r_fs_pos;
        n_buf      = r_buf;
        n_ncol     = r_ncol;
        if (i_head.beat.char_class == CLS_POINT) begin
            n_pt_seen = 1'b1;
            n_pt_pos  = r_pos;
        end
        if (i_head.beat.char_class == CLS_DIGIT) begin
            if (i_head.beat.digit != '0 && !r_sig_seen) begin
                n_sig_seen = 1'b1;
                n_fs_pos   = r_pos;
            end
            if (n_sig_seen && r_ncol < i_cnt) begin
                for (int k = 0; k < MAX_DIGITS; k++) begin
                    if (r_ncol[CNT_W-2:0] == (CNT_W - 1)'(k)) begin
                        n_buf[SIG_W-1-DIG_W*k -: DIG_W] = i_head.beat.digit;
                    end
                end
                n_ncol = r_ncol + 1'b1;
            end
        end
        if (i_head.beat.char_class != CLS_OTHER && r_pos < POS_W'(MAX_CHARS)) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Keep only the leading digits of the current digit count.
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            s_mask[SIG_W-1-DIG_W*k -: DIG_W] = (CNT_W'(k) < i_cnt) ? '1 : '0;
        end
    end

    // Exponent of the 0.ddd form, saturated to the range -128 to 128.
    always_comb begin
        s_zero     = !n_sig_seen;
        s_digs     = s_zero ? '0 : (n_buf & s_mask);
        s_dp       = n_pt_seen ? n_pt_pos : n_pos;
        s_diff     = $signed(DIFF_W'(s_dp)) - $signed(DIFF_W'(n_fs_pos));
        s_diff_adj = (s_diff < 0) ? s_diff + DIFF_W'(1) : s_diff;
        if (s_zero) begin
            s_exp = '0;
        end else if (s_diff_adj > $signed(DIFF_W'(EXP_LIMIT))) begin
            s_exp = EXP_W'(EXP_LIMIT);
        end else if (s_diff_adj < -$signed(DIFF_W'(EXP_LIMIT))) begin
            s_exp = -$signed(EXP_W'(EXP_LIMIT));
        end else begin
            s_exp = EXP_W'(s_diff_adj);
        end
    end

    // Compare the second number with the saved first one.
    always_comb begin
        s_eq = 1'b0;
        if (i_head.beat.mode) begin
            if (s_zero || r_sv_zero) begin
                s_eq = s_zero && r_sv_zero;
            end else begin
                s_eq = (s_exp == r_sv_exp) && ((r_sv_digs & s_mask) == s_digs);
            end
        end
    end

    // Number state, saved first number and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_pt_seen   <= 1'b0;
            r_pt_pos    <= '0;
            r_sig_seen  <= 1'b0;
            r_fs_pos    <= '0;
            r_buf       <= '0;
            r_ncol      <= '0;
            r_sv_digs   <= '0;
            r_sv_exp    <= '0;
            r_sv_zero   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (s_finish) begin
                r_pos      <= '0;
                r_pt_seen  <= 1'b0;
                r_pt_pos   <= '0;
                r_sig_seen <= 1'b0;
                r_fs_pos   <= '0;
                r_buf      <= '0;
                r_ncol     <= '0;
                if (!i_head.beat.mode) begin
                    r_sv_digs <= s_digs;
                    r_sv_exp  <= s_exp;
                    r_sv_zero <= s_zero;
                end
            end else if (s_take) begin
                r_pos      <= n_pos;
                r_pt_seen  <= n_pt_seen;
                r_pt_pos   <= n_pt_pos;
                r_sig_seen <= n_sig_seen;
                r_fs_pos   <= n_fs_pos;
                r_buf      <= n_buf;
                r_ncol     <= n_ncol;
            end
            if (s_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (s_finish) begin
            r_out_which <= i_head.beat.mode;
            r_out_digs  <= s_digs;
            r_out_exp   <= s_exp;
            r_out_zero  <= s_zero;
            r_out_eq    <= s_eq;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.which_number    = r_out_which;
    assign o_res.significand_bcd = r_out_digs;
    assign o_res.exponent        = r_out_exp;
    assign o_res.is_zero         = r_out_zero;
    assign o_res.numbers_equal   = r_out_eq;

endmodule

[rtl/decimal_sci_normalize_compare.sv]
// Top level of the decimal string normalizer with first/second number compare.
//
// Characters of two unsigned decimal numbers arrive on i_in, one per beat:
// digits and the point, first number with mode 0, second with mode 1, the
// final character of each marked by last_char. Other codes are skipped.
// Each number yields one beat on o_res: the BCD significand truncated or
// zero-padded to the configured digit count, the exponent of the 0.ddd form,
// a zero flag and, on the second number, whether both forms agree.
// i_cfg_we/i_cfg_data set the digit count (1 to 16, reset 16); the user
// must write it only while idle, which the block itself does not enforce.
// Throughput is one character per cycle while the queue has a free slot. A
// final character is written into the four-entry queue, then the digit
// tracker loads its result into the output register, which drives o_res.
// Reset empties the queue, clears the number state, marks the saved first
// number as zero and drops o_res.valid. While o_res is stalled the result
// holds, the tracker keeps taking non-final characters and the queue keeps
// accepting until its four entries are full.
module decimal_sci_normalize_compare
    import dscn_pkg::*;
#(
    parameter int MAX_CHARS = 128
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dscn_in_if.sink          i_in,
    dscn_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int POS_W = $clog2(MAX_CHARS + 1);

    logic [CNT_W-1:0] r_sig_digits;
    logic [CNT_W-1:0] s_cnt;
    t_queue_head      s_head;
    logic             s_pop;

    // Digit count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_digits <= SIG_DIGITS_RESET;
        end else if (i_cfg_we) begin
            r_sig_digits <= i_cfg_data;
        end
    end

    // Effective digit count: zero acts as one, capped at the buffer size.
    always_comb begin
        if (r_sig_digits == '0) begin
            s_cnt = CNT_W'(1);
        end else if (r_sig_digits > CNT_W'(MAX_DIGITS)) begin
            s_cnt = CNT_W'(MAX_DIGITS);
        end else begin
            s_cnt = r_sig_digits;
        end
    end

    dscn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (s_head),
        .i_pop   (s_pop)
    );

    dscn_back #(
        .MAX_CHARS (MAX_CHARS),
        .POS_W     (POS_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt   (s_cnt),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .o_res   (o_res)
    );

endmodule

[rtl/dscn_checker.sv]
// Port-level checks for the normalizer, bound to its top level.
`include "decimal_sci_normalize_compare_defines.svh"

module dscn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic              i_which,
    input logic [63:0]       i_digs,
    input logic signed [8:0] i_exp,
    input logic              i_zero,
    input logic              i_eq
);

    // A stalled result beat holds its value.
    `DSCN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_digs) && $stable(i_exp) && $stable(i_which), "result changed while stalled")

    // The first number's result never reports a match.
    `DSCN_ASSERT_IMP(a_first_no_eq, i_clk, i_rst_n, i_valid && !i_which, !i_eq, "match flag set on first number")

    // A zero number has exponent and significand zero.
    `DSCN_ASSERT_IMP(a_zero_form, i_clk, i_rst_n, i_valid && i_zero, i_exp == 9'sd0 && i_digs == 64'd0, "zero result not cleared")

    // A nonzero number starts with its first nonzero digit.
    `DSCN_ASSERT_IMP(a_lead_digit, i_clk, i_rst_n, i_valid && !i_zero, i_digs[63:60] != 4'd0, "nonzero result has leading zero digit")

endmodule

bind decimal_sci_normalize_compare dscn_checker u_dscn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_which (o_res.which_number),
    .i_digs  (o_res.significand_bcd),
    .i_exp   (o_res.exponent),
    .i_zero  (o_res.is_zero),
    .i_eq    (o_res.numbers_equal)
);
